[rtl/rbrm_pkg.sv]
// Shared types and constants of the shadow bitmap range marker.
`default_nettype none
package rbrm_pkg;

   localparam int ADDR_BITS_DEFAULT     = 20;
   localparam int GRANULE_BYTES_DEFAULT = 16;

   localparam int BASE_W   = 20;
   localparam int LEN_W    = 21;
   localparam int SUM_W    = 22;
   localparam int WIDX_W   = 10;
   localparam int WORD_W   = 64;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SKIPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

   localparam logic REQ_MARK  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [BASE_W-1:0] obj_base;
      logic [LEN_W-1:0]  obj_len;
      logic              obj_tagged;
   } rbrm_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WIDX_W-1:0]   first_word_index;
      logic [WIDX_W-1:0]   last_word_index;
      logic [WORD_W-1:0]   first_word_mask;
      logic [WORD_W-1:0]   last_word_mask;
   } rbrm_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic clear_step;
      logic write_first;
      logic write_last;
      logic fill_start;
      logic fill_step;
      logic set_skip;
      logic load_rsp;
   } rbrm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic oor;
      logic in_map;
      logic skip;
      logic multi;
      logic fill_more;
   } rbrm_stat_type;

endpackage
`default_nettype wire

[rtl/revocation_bitmap_range_marker_core.sv]
// Top level of the shadow bitmap range marker.
`default_nettype none
// Keeps a shadow bitmap of one bit per granule of the covered region in a
// word memory with one read and one write port, and marks or clears the
// granules of one object per request, answering each request with one result
// transfer. After reset the block first clears the memory, one word a cycle,
// and stalls requests until every word is cleared (1024 words with the default
// parameters). For an object within one word, a skipped mark and an out-of-range
// request, the transfer reads the first word and the check state tests it and
// writes it if the request goes ahead. An object spanning words writes the first
// word in the check state, the last word in the last state and each whole word
// between in the fill state, one write each. A finished result waits in an
// output register, so a stalled result channel does not hold up the next request
// until that request itself finishes. GRANULE_BYTES must be a power of two.
module revocation_bitmap_range_marker_core #(
   parameter int ADDR_BITS     = rbrm_pkg::ADDR_BITS_DEFAULT,
   parameter int GRANULE_BYTES = rbrm_pkg::GRANULE_BYTES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rbrm_pkg::rbrm_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rbrm_pkg::rbrm_rsp_type      rsp_data
);
   import rbrm_pkg::*;

   rbrm_cmd_type  cmd;
   rbrm_stat_type stat;

   rbrm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rbrm_datapath #(
      .ADDR_BITS     (ADDR_BITS),
      .GRANULE_BYTES (GRANULE_BYTES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // A result is never loaded over one that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // No memory write happens in the cycle of an input transfer.
   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |->
         !(cmd.clear_step || cmd.write_first || cmd.write_last || cmd.fill_step))
      else $error("memory written during an input transfer");

   // The last word is written only straight after the first word.
   a_last_after_first: assert property (@(posedge clock) disable iff (reset)
      cmd.write_last |-> $past(cmd.write_first))
      else $error("last word written without a preceding first-word write");

endmodule
`default_nettype wire

[rtl/rbrm_datapath.sv]
// Datapath: range and mask arithmetic, shadow bitmap memory and result register.
`default_nettype none
module rbrm_datapath #(
   parameter int ADDR_BITS     = rbrm_pkg::ADDR_BITS_DEFAULT,
   parameter int GRANULE_BYTES = rbrm_pkg::GRANULE_BYTES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rbrm_pkg::rbrm_req_type req_data,
   input  wire rbrm_pkg::rbrm_cmd_type cmd,
   output rbrm_pkg::rbrm_stat_type     stat,
   output rbrm_pkg::rbrm_rsp_type      rsp_data
);
   import rbrm_pkg::*;

   // GRANULE_BYTES is taken to be a power of two.
   localparam int GSHIFT = $clog2(GRANULE_BYTES);
   localparam longint NWORDS =
      ((64'd1 << ADDR_BITS) / GRANULE_BYTES + 63) / 64;
   localparam int WORD_BITS = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int IDX_W = (WORD_BITS > SUM_W) ? WORD_BITS : SUM_W;
   localparam logic [32:0] REGION = 33'd1 << ADDR_BITS;
   localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

   logic [WORD_W-1:0] mem [int'(NWORDS)];

   logic [SUM_W-1:0] sum_c, g0_c, gl_c, width_c;
   logic [IDX_W-1:0] fw_c, lw_c;
   logic [5:0] lsb_c, msb_c, end_c;
   logic oor_c, multi_c, in_map_c, wide_c;
   logic [WORD_W-1:0] fwm_c, lwm_c;

   logic              oor_ff, multi_ff, in_map_ff, type_ff, tagged_ff, skip_ff;
   logic [IDX_W-1:0]  fw_ff, lw_ff, w_ff;
   logic [WORD_W-1:0] fwm_ff, lwm_ff, rdata_ff;
   logic [WORD_BITS-1:0] clr_ff;
   rbrm_rsp_type rsp_ff;

   logic                 we;
   logic [WORD_BITS-1:0] waddr, raddr;
   logic [WORD_W-1:0]    wdata;
   logic                 mark;
   logic                 skip_now;

   always_comb begin
      sum_c   = SUM_W'(req_data.obj_base) + SUM_W'(req_data.obj_len);
      oor_c   = 33'(sum_c) > REGION;
      g0_c    = SUM_W'(req_data.obj_base) >> GSHIFT;
      gl_c    = (req_data.obj_len == '0) ? g0_c : ((sum_c - SUM_W'(1)) >> GSHIFT);
      width_c = SUM_W'(req_data.obj_len) >> GSHIFT;
      fw_c    = IDX_W'(g0_c >> 6);
      lw_c    = IDX_W'(gl_c >> 6);
      lsb_c   = g0_c[5:0];
      msb_c   = gl_c[5:0];
      multi_c = fw_c != lw_c;
      in_map_c = (33'(fw_c) < 33'(NWORDS)) && (33'(lw_c) < 33'(NWORDS));
      wide_c  = (SUM_W'(lsb_c) + width_c) >= SUM_W'(64);
      end_c   = lsb_c + width_c[5:0];
      if (multi_c || wide_c) begin
         fwm_c = ONES << lsb_c;
      end else begin
         fwm_c = (ONES << lsb_c) & ~(ONES << end_c);
      end
      lwm_c = multi_c ? (ONES >> (6'd63 - msb_c)) : '0;
   end

   // Request fields and derived values are captured on the input transfer.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         oor_ff    <= oor_c;
         multi_ff  <= multi_c;
         in_map_ff <= in_map_c;
         type_ff   <= req_data.req_type;
         tagged_ff <= req_data.obj_tagged;
         fw_ff     <= fw_c;
         lw_ff     <= lw_c;
         fwm_ff    <= fwm_c;
         lwm_ff    <= lwm_c;
      end
      if (cmd.fill_start) begin
         w_ff <= fw_ff + IDX_W'(1);
      end else if (cmd.fill_step) begin
         w_ff <= w_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         skip_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + WORD_BITS'(1);
         end
         if (cmd.accept) begin
            skip_ff <= 1'b0;
         end else if (cmd.set_skip) begin
            skip_ff <= 1'b1;
         end
      end
   end

   assign mark     = type_ff == REQ_MARK;
   assign skip_now = mark && (!tagged_ff || ((rdata_ff & fwm_ff) != '0));

   // The first word is read on the transfer and the last word while the first
   // is written, so each read-modify-write sees its own word.
   always_comb begin
      we    = 1'b0;
      waddr = clr_ff;
      wdata = '0;
      raddr = cmd.accept ? fw_c[WORD_BITS-1:0] : lw_ff[WORD_BITS-1:0];
      if (cmd.clear_step) begin
         we = 1'b1;
      end else if (cmd.write_first) begin
         we    = 1'b1;
         waddr = fw_ff[WORD_BITS-1:0];
         wdata = mark ? (rdata_ff | fwm_ff) : (rdata_ff & ~fwm_ff);
      end else if (cmd.write_last) begin
         we    = 1'b1;
         waddr = lw_ff[WORD_BITS-1:0];
         wdata = mark ? (rdata_ff | lwm_ff) : (rdata_ff & ~lwm_ff);
      end else if (cmd.fill_step) begin
         we    = 1'b1;
         waddr = w_ff[WORD_BITS-1:0];
         wdata = mark ? ONES : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (oor_ff) begin
            rsp_ff <= '{status: STATUS_RANGE, first_word_index: '0,
                        last_word_index: '0, first_word_mask: '0,
                        last_word_mask: '0};
         end else begin
            rsp_ff.status <= (skip_ff || cmd.set_skip) ? STATUS_SKIPPED : STATUS_DONE;
            rsp_ff.first_word_index <= fw_ff[WIDX_W-1:0];
            rsp_ff.last_word_index  <= lw_ff[WIDX_W-1:0];
            rsp_ff.first_word_mask  <= fwm_ff;
            rsp_ff.last_word_mask   <= lwm_ff;
         end
      end
   end

   assign rsp_data = rsp_ff;

   always_comb begin
      stat.clear_last = clr_ff == WORD_BITS'(NWORDS - 1);
      stat.oor        = oor_ff;
      stat.in_map     = in_map_ff;
      stat.skip       = skip_now;
      stat.multi      = multi_ff;
      stat.fill_more  = w_ff < lw_ff;
   end

endmodule
`default_nettype wire

[rtl/rbrm_controller.sv]
// Controller: sequences the clearing pass and the word writes of each request.
`default_nettype none
module rbrm_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire rbrm_pkg::rbrm_stat_type stat,
   output rbrm_pkg::rbrm_cmd_type       cmd
);
   import rbrm_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_LAST  = 6'b001000,
      ST_FILL  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.oor || !stat.in_map || stat.skip) begin
               cmd.set_skip = !stat.oor && stat.in_map;
               cmd.load_rsp = rsp_free;
               state_in     = rsp_free ? ST_IDLE : ST_DONE;
            end else begin
               cmd.write_first = 1'b1;
               if (stat.multi) begin
                  state_in = ST_LAST;
               end else begin
                  cmd.load_rsp = rsp_free;
                  state_in     = rsp_free ? ST_IDLE : ST_DONE;
               end
            end
         end
         ST_LAST: begin
            cmd.write_last = 1'b1;
            cmd.fill_start = 1'b1;
            state_in       = ST_FILL;
         end
         ST_FILL: begin
            if (stat.fill_more) begin
               cmd.fill_step = 1'b1;
            end else begin
               cmd.load_rsp = rsp_free;
               state_in     = rsp_free ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[test/tb.sv]
// Testbench of the shadow bitmap range marker: queued stimulus, bitmap predictor, result checker.
`default_nettype none
module tb;
   import rbrm_pkg::*;

   localparam int unsigned GRANULE_SIZE = GRANULE_BYTES_DEFAULT;
   localparam int unsigned REGION_BYTES = 32'd1 << ADDR_BITS_DEFAULT;
   localparam int unsigned MAP_WORDS    = REGION_BYTES / GRANULE_SIZE / 64;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned RANDOM_ITEMS = 260;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   rbrm_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rbrm_rsp_type rsp_data;

   logic [WORD_W-1:0] shadow_map [MAP_WORDS];
   rbrm_req_type      queued_reqs [$];
   rbrm_rsp_type      awaited_rsps [$];
   rbrm_rsp_type      oldest_rsp;

   int unsigned req_idle_pct  = 35;
   int unsigned rsp_idle_pct  = 77;
   int unsigned hold_asked    = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;

   revocation_bitmap_range_marker_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic logic [WORD_W-1:0] granule_mask_below(int unsigned n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
   endfunction

   // Applies one request to the predicted bitmap and returns the result it should give.
   function automatic rbrm_rsp_type apply_range_request(rbrm_req_type r);
      rbrm_rsp_type      res;
      int unsigned       obj_end, g0, g1, fw, lw, lsb, span, w;
      logic [WORD_W-1:0] fwm, lwm;
      res = '0;
      obj_end = r.obj_base + r.obj_len;
      if (obj_end > REGION_BYTES) begin
         res.status = STATUS_RANGE;
         return res;
      end
      g0 = r.obj_base / GRANULE_SIZE;
      g1 = (r.obj_len == 0) ? g0 : (obj_end - 1) / GRANULE_SIZE;
      fw = g0 / 64;
      lw = g1 / 64;
      lsb = g0 % 64;
      if (fw == lw) begin
         // The bit count comes from the length alone, even when the base is unaligned.
         span = r.obj_len / GRANULE_SIZE;
         if (lsb + span >= 64)
            fwm = ~granule_mask_below(lsb);
         else
            fwm = granule_mask_below(lsb + span) & ~granule_mask_below(lsb);
         lwm = '0;
      end else begin
         fwm = ~granule_mask_below(lsb);
         lwm = granule_mask_below(g1 % 64 + 1);
      end
      res.status = STATUS_DONE;
      if (r.req_type == REQ_MARK) begin
         // A mark only goes ahead when none of its first-word bits is set yet.
         if (!r.obj_tagged || (shadow_map[fw] & fwm) != '0) begin
            res.status = STATUS_SKIPPED;
         end else begin
            shadow_map[fw] |= fwm;
            if (lw != fw) begin
               shadow_map[lw] |= lwm;
               for (w = fw + 1; w < lw; w++)
                  shadow_map[w] = '1;
            end
         end
      end else begin
         shadow_map[fw] &= ~fwm;
         if (lw != fw) begin
            shadow_map[lw] &= ~lwm;
            for (w = fw + 1; w < lw; w++)
               shadow_map[w] = '0;
         end
      end
      res.first_word_index = WIDX_W'(fw);
      res.last_word_index  = WIDX_W'(lw);
      res.first_word_mask  = fwm;
      res.last_word_mask   = lwm;
      return res;
   endfunction

   function automatic rbrm_req_type random_request();
      rbrm_req_type r;
      int unsigned  pick, word;
      pick = $urandom_range(99);
      r.req_type   = ($urandom_range(99) < 40) ? REQ_CLEAR : REQ_MARK;
      r.obj_tagged = ($urandom_range(99) < 85);
      if (pick < 70) begin
         // Small aligned objects in a few hot words, so that marks and clears collide.
         word = $urandom_range(15);
         r.obj_base = BASE_W'(word * 1024 + $urandom_range(63) * GRANULE_SIZE);
         r.obj_len  = LEN_W'($urandom_range(80) * GRANULE_SIZE);
      end else if (pick < 82) begin
         r.obj_base = BASE_W'($urandom_range(65535) * GRANULE_SIZE);
         r.obj_len  = LEN_W'($urandom_range(200) * GRANULE_SIZE);
      end else if (pick < 90) begin
         r.obj_base = BASE_W'($urandom);
         r.obj_len  = LEN_W'($urandom_range(3000));
      end else if (pick < 94) begin
         r.obj_base = BASE_W'(REGION_BYTES - 1 - $urandom_range(4095));
         r.obj_len  = LEN_W'($urandom_range(100000, 4097));
      end else if (pick < 96) begin
         r.obj_base = BASE_W'($urandom);
         r.obj_len  = LEN_W'($urandom);
      end else begin
         word = $urandom_range(MAP_WORDS - 1);
         r.obj_base = BASE_W'(word * 1024);
         r.obj_len  = LEN_W'($urandom_range((REGION_BYTES - word * 1024) / GRANULE_SIZE, 1)
                             * GRANULE_SIZE);
      end
      return r;
   endfunction

   task automatic queue_request(logic kind, int unsigned base, int unsigned len, logic tag_bit);
      rbrm_req_type r;
      r.req_type   = kind;
      r.obj_base   = BASE_W'(base);
      r.obj_len    = LEN_W'(len);
      r.obj_tagged = tag_bit;
      queued_reqs.push_back(r);
   endtask

   task automatic queue_random(int unsigned count);
      repeat (count) queued_reqs.push_back(random_request());
   endtask

   task automatic wait_drained();
      while (queued_reqs.size() != 0 || awaited_rsps.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: the prediction is made when the transfer happens.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_rsps.push_back(apply_range_request(req_data));
            void'(queued_reqs.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (queued_reqs.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= queued_reqs[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result stall, with a long hold-off whenever one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result at cycle %0d: status %0d words %0d..%0d",
                        cycle_count, rsp_data.status, rsp_data.first_word_index,
                        rsp_data.last_word_index);
         end else begin
            oldest_rsp = awaited_rsps.pop_front();
            if (rsp_data.status !== oldest_rsp.status
                || rsp_data.first_word_index !== oldest_rsp.first_word_index
                || rsp_data.last_word_index !== oldest_rsp.last_word_index
                || rsp_data.first_word_mask !== oldest_rsp.first_word_mask
                || rsp_data.last_word_mask !== oldest_rsp.last_word_mask) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result mismatch at cycle %0d: expected %0d %0d..%0d %h %h,",
                           cycle_count, oldest_rsp.status, oldest_rsp.first_word_index,
                           oldest_rsp.last_word_index, oldest_rsp.first_word_mask,
                           oldest_rsp.last_word_mask);
                  $display("   got %0d %0d..%0d %h %h", rsp_data.status,
                           rsp_data.first_word_index, rsp_data.last_word_index,
                           rsp_data.first_word_mask, rsp_data.last_word_mask);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < MAP_WORDS; i++)
         shadow_map[i] = '0;

      // Single granule: mark, repeated mark, untagged mark, then clear.
      queue_request(REQ_MARK, 0, 16, 1'b1);
      queue_request(REQ_MARK, 0, 16, 1'b1);
      queue_request(REQ_MARK, 32, 16, 1'b0);
      queue_request(REQ_CLEAR, 0, 16, 1'b0);
      // Zero length objects.
      queue_request(REQ_MARK, 'h100, 0, 1'b1);
      queue_request(REQ_CLEAR, 'h100, 0, 1'b0);
      // The whole region, then the last granule and the region end.
      queue_request(REQ_MARK, 0, REGION_BYTES, 1'b1);
      queue_request(REQ_CLEAR, 0, REGION_BYTES, 1'b1);
      queue_request(REQ_MARK, REGION_BYTES - 16, 16, 1'b1);
      queue_request(REQ_MARK, REGION_BYTES - 16, 32, 1'b1);
      queue_request(REQ_MARK, REGION_BYTES - 1, 1, 1'b1);
      queue_request(REQ_CLEAR, REGION_BYTES - 1, 'h1FFFFF, 1'b1);
      queue_request(REQ_CLEAR, REGION_BYTES - 16, 16, 1'b0);
      // Objects crossing word boundaries.
      queue_request(REQ_MARK, 'h3F0, 32, 1'b1);
      queue_request(REQ_MARK, 'h3F0, 32, 1'b1);
      queue_request(REQ_CLEAR, 'h3F0, 32, 1'b0);
      queue_request(REQ_MARK, 'h3F0, 'h420, 1'b1);
      queue_request(REQ_CLEAR, 'h3F0, 'h420, 1'b1);
      // Unaligned base and length, and a mask reaching the top bit of a word.
      queue_request(REQ_MARK, 15, 2, 1'b1);
      queue_request(REQ_MARK, 'h400, 'h17, 1'b1);
      queue_request(REQ_MARK, 'h200, 'h200, 1'b1);
      queue_request(REQ_CLEAR, 'h200, 'h200, 1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      queue_random(RANDOM_ITEMS);
      wait_drained();

      req_idle_pct = 77;
      rsp_idle_pct = 35;
      queue_random(RANDOM_ITEMS);
      wait_drained();

      // No idling; the receiver holds off at the start while the sender keeps offering.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_asked++;
      queue_random(RANDOM_ITEMS);
      wait_drained();

      repeat (100) @(negedge clock);
      if (mismatches == 0 && awaited_rsps.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
